### rtl/core/ecgim_pkg.sv
// Package for the eight-color grid index mapper: widths, codes, shared types
// and small helper functions. No dependencies.
`default_nettype none

package ecgim_pkg;

  localparam int RESO_W        = 11;
  localparam int ID_W          = 31;
  localparam int POS_W         = 12;
  localparam int DIM_W         = 10;
  localparam int DXDY_W        = 20;
  localparam int AREA_W        = 21;
  localparam int CNT_W         = 28;
  localparam int M1_W          = 22;
  localparam int M2_W          = 32;
  localparam int NUM_COLORS    = 8;
  localparam int COLOR_W       = 3;
  localparam int OP_W          = 2;
  localparam int MAX_AXIS_RESO = 1024;
  localparam int SET_ALIGN_LOG = 5;
  localparam int SET_ALIGN     = 1 << SET_ALIGN_LOG;
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 32;

  localparam logic [RESO_W-1:0] RESO_RESET = RESO_W'(128);

  localparam logic [OP_W-1:0] OP_LEX2COL = 2'd0;
  localparam logic [OP_W-1:0] OP_COL2POS = 2'd1;
  localparam logic [OP_W-1:0] OP_COL2LEX = 2'd2;

  localparam logic [1:0] REG_RESO_X = 2'd0;
  localparam logic [1:0] REG_RESO_Y = 2'd1;
  localparam logic [1:0] REG_RESO_Z = 2'd2;

  typedef enum logic [2:0] {
    CFG_IDLE,
    CFG_CLAMP,
    CFG_AREA,
    CFG_VOL,
    CFG_CMUL1,
    CFG_CMUL2,
    CFG_CACC
  } cfg_state_t;

  typedef struct packed {
    logic                                busy;
    logic [2:0][RESO_W-1:0]              reso;
    logic [1:0][DIM_W-1:0]               dim_x;
    logic [1:0][DIM_W-1:0]               dim_y;
    logic [NUM_COLORS-1:0][DXDY_W-1:0]   dxdy;
    logic [NUM_COLORS-1:0][ID_W-1:0]     set_ends;
    logic [1:0][AREA_W-1:0]              area;
    logic [1:0][ID_W-1:0]                vol;
  } tables_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               per;
    logic               bad;
    logic [COLOR_W-1:0] color;
    logic [ID_W-1:0]    num;
    logic [RESO_W-1:0]  d1;
    logic [RESO_W-1:0]  d2;
  } q_entry_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               per;
    logic               bad;
    logic [COLOR_W-1:0] color;
    logic [RESO_W-1:0]  d2;
  } div1_pay_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               per;
    logic               bad;
    logic [COLOR_W-1:0] color;
    logic [RESO_W-1:0]  r0;
  } div2_pay_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic                    per;
    logic                    bad;
    logic [COLOR_W-1:0]      color;
    logic [2:0][RESO_W-1:0]  ph;
    logic [2:0][POS_W-1:0]   pos;
  } post_t;

  typedef struct packed {
    logic [OP_W-1:0]        op;
    logic                   bad;
    logic [COLOR_W-1:0]     color;
    logic [2:0][POS_W-1:0]  pos;
    logic [RESO_W-1:0]      a0;
    logic [M1_W-1:0]        m1;
    logic [M2_W-1:0]        m2;
    logic [ID_W-1:0]        base;
  } mul_t;

  function automatic logic [RESO_W-1:0] clamp_reso(input logic [RESO_W-1:0] r);
    logic [RESO_W-1:0] res;
    if (r == '0) begin
      res = RESO_W'(1);
    end else if (r > RESO_W'(MAX_AXIS_RESO)) begin
      res = RESO_W'(MAX_AXIS_RESO);
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] set_dim(input logic [RESO_W-1:0] rc, input logic par);
    logic [RESO_W:0] s;
    logic [RESO_W:0] d;
    s = {1'b0, rc} + (RESO_W+1)'(2) - {{RESO_W{1'b0}}, par};
    d = (s >> 1) + (RESO_W+1)'(1);
    return d[DIM_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/ecgim_in_if.sv
// Input channel of the index mapper: valid/ready plus one translation request.
// Depends on ecgim_pkg.
`default_nettype none

interface ecgim_in_if;
  logic                            valid;
  logic                            ready;
  logic [ecgim_pkg::OP_W-1:0]      operation;
  logic [ecgim_pkg::ID_W-1:0]      index_in;
  logic                            period_dof;

  modport source(output valid, operation, index_in, period_dof, input ready);
  modport sink(input valid, operation, index_in, period_dof, output ready);
endinterface

`default_nettype wire

### rtl/core/ecgim_out_if.sv
// Output channel of the index mapper: valid/ready plus one translation result.
// Depends on ecgim_pkg.
`default_nettype none

interface ecgim_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [ecgim_pkg::ID_W-1:0]           index_out;
  logic signed [ecgim_pkg::POS_W-1:0]   pos_x;
  logic signed [ecgim_pkg::POS_W-1:0]   pos_y;
  logic signed [ecgim_pkg::POS_W-1:0]   pos_z;
  logic [ecgim_pkg::COLOR_W-1:0]        color;
  logic                                 bad_index;

  modport source(output valid, index_out, pos_x, pos_y, pos_z, color, bad_index,
                 input ready);
  modport sink(input valid, index_out, pos_x, pos_y, pos_z, color, bad_index,
               output ready);
endinterface

`default_nettype wire

### rtl/core/ecgim_cfg.sv
// Register port and table sequencer: resolution registers, then set dims,
// set ends, areas and volumes derived state by state. Depends on ecgim_pkg.
`default_nettype none

module ecgim_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ecgim_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ecgim_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ecgim_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready,
  output ecgim_pkg::tables_t                   tables
);

  ecgim_pkg::cfg_state_t state, state_next;

  logic [ecgim_pkg::RESO_W-1:0] reso_x, reso_y, reso_z;
  logic [2:0][ecgim_pkg::RESO_W-1:0] rc;
  logic [1:0][ecgim_pkg::DIM_W-1:0] dim_x, dim_y, dim_z;
  logic [1:0][ecgim_pkg::AREA_W-1:0] area;
  logic [1:0][ecgim_pkg::ID_W-1:0] vol;
  logic [ecgim_pkg::NUM_COLORS-1:0][ecgim_pkg::DXDY_W-1:0] dxdy;
  logic [ecgim_pkg::NUM_COLORS-1:0][ecgim_pkg::ID_W-1:0] set_ends;
  logic [ecgim_pkg::COLOR_W-1:0] cidx;
  logic [ecgim_pkg::DXDY_W-1:0] prod_xy;
  logic [ecgim_pkg::CNT_W-1:0] cnt;
  logic [31:0] end_acc;

  logic       write;
  logic [1:0] widx;
  logic       wr_valid;

  logic [ecgim_pkg::RESO_W:0]     rc0p, rc1p, rc2p;
  logic [2*ecgim_pkg::RESO_W+1:0] area0_full, area1_full;
  logic [ecgim_pkg::AREA_W+ecgim_pkg::RESO_W:0] vol0_full, vol1_full;
  logic [2*ecgim_pkg::DIM_W-1:0]  xy_full;
  logic [ecgim_pkg::DXDY_W+ecgim_pkg::DIM_W-1:0] cnt_full;
  logic [ecgim_pkg::CNT_W:0]      rnd_sum;
  logic [ecgim_pkg::CNT_W:0]      rnd;
  logic [31:0]                    acc_next;

  assign write    = psel && penable && pwrite;
  assign widx     = paddr[3:2];
  assign wr_valid = write && (widx == ecgim_pkg::REG_RESO_X ||
                              widx == ecgim_pkg::REG_RESO_Y ||
                              widx == ecgim_pkg::REG_RESO_Z);
  assign pready   = 1'b1;

  always_comb begin
    case (widx)
      ecgim_pkg::REG_RESO_X: prdata = ecgim_pkg::PDATA_W'(reso_x);
      ecgim_pkg::REG_RESO_Y: prdata = ecgim_pkg::PDATA_W'(reso_y);
      ecgim_pkg::REG_RESO_Z: prdata = ecgim_pkg::PDATA_W'(reso_z);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ecgim_pkg::CFG_IDLE:  state_next = ecgim_pkg::CFG_IDLE;
      ecgim_pkg::CFG_CLAMP: state_next = ecgim_pkg::CFG_AREA;
      ecgim_pkg::CFG_AREA:  state_next = ecgim_pkg::CFG_VOL;
      ecgim_pkg::CFG_VOL:   state_next = ecgim_pkg::CFG_CMUL1;
      ecgim_pkg::CFG_CMUL1: state_next = ecgim_pkg::CFG_CMUL2;
      ecgim_pkg::CFG_CMUL2: state_next = ecgim_pkg::CFG_CACC;
      ecgim_pkg::CFG_CACC: begin
        if (cidx == ecgim_pkg::COLOR_W'(ecgim_pkg::NUM_COLORS - 1)) begin
          state_next = ecgim_pkg::CFG_IDLE;
        end else begin
          state_next = ecgim_pkg::CFG_CMUL1;
        end
      end
      default: state_next = ecgim_pkg::CFG_IDLE;
    endcase
    if (wr_valid) begin
      state_next = ecgim_pkg::CFG_CLAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecgim_pkg::CFG_CLAMP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reso_x <= ecgim_pkg::RESO_RESET;
      reso_y <= ecgim_pkg::RESO_RESET;
      reso_z <= ecgim_pkg::RESO_RESET;
      cidx   <= '0;
    end else begin
      if (wr_valid) begin
        case (widx)
          ecgim_pkg::REG_RESO_X: reso_x <= pwdata[ecgim_pkg::RESO_W-1:0];
          ecgim_pkg::REG_RESO_Y: reso_y <= pwdata[ecgim_pkg::RESO_W-1:0];
          ecgim_pkg::REG_RESO_Z: reso_z <= pwdata[ecgim_pkg::RESO_W-1:0];
          default: ;
        endcase
      end
      if (state == ecgim_pkg::CFG_VOL) begin
        cidx <= '0;
      end else if (state == ecgim_pkg::CFG_CACC) begin
        cidx <= cidx + ecgim_pkg::COLOR_W'(1);
      end
    end
  end

  always_comb begin
    rc0p       = {1'b0, rc[0]} + (ecgim_pkg::RESO_W+1)'(1);
    rc1p       = {1'b0, rc[1]} + (ecgim_pkg::RESO_W+1)'(1);
    rc2p       = {1'b0, rc[2]} + (ecgim_pkg::RESO_W+1)'(1);
    area0_full = {1'b0, rc[0]} * {1'b0, rc[1]};
    area1_full = rc0p * rc1p;
    vol0_full  = area[0] * {1'b0, rc[2]};
    vol1_full  = area[1] * rc2p;
    xy_full    = dim_x[cidx[0]] * dim_y[cidx[1]];
    cnt_full   = prod_xy * dim_z[cidx[2]];
    rnd_sum    = {1'b0, cnt} + (ecgim_pkg::CNT_W+1)'(ecgim_pkg::SET_ALIGN - 1);
    rnd        = {rnd_sum[ecgim_pkg::CNT_W:ecgim_pkg::SET_ALIGN_LOG],
                  {ecgim_pkg::SET_ALIGN_LOG{1'b0}}};
    acc_next   = end_acc + 32'(rnd);
  end

  always_ff @(posedge clk) begin
    case (state)
      ecgim_pkg::CFG_CLAMP: begin
        rc[0] <= ecgim_pkg::clamp_reso(reso_x);
        rc[1] <= ecgim_pkg::clamp_reso(reso_y);
        rc[2] <= ecgim_pkg::clamp_reso(reso_z);
      end
      ecgim_pkg::CFG_AREA: begin
        dim_x[0] <= ecgim_pkg::set_dim(rc[0], 1'b0);
        dim_x[1] <= ecgim_pkg::set_dim(rc[0], 1'b1);
        dim_y[0] <= ecgim_pkg::set_dim(rc[1], 1'b0);
        dim_y[1] <= ecgim_pkg::set_dim(rc[1], 1'b1);
        dim_z[0] <= ecgim_pkg::set_dim(rc[2], 1'b0);
        dim_z[1] <= ecgim_pkg::set_dim(rc[2], 1'b1);
        area[0]  <= area0_full[ecgim_pkg::AREA_W-1:0];
        area[1]  <= area1_full[ecgim_pkg::AREA_W-1:0];
      end
      ecgim_pkg::CFG_VOL: begin
        vol[0]  <= vol0_full[ecgim_pkg::ID_W-1:0];
        vol[1]  <= vol1_full[ecgim_pkg::ID_W-1:0];
        end_acc <= '0;
      end
      ecgim_pkg::CFG_CMUL1: begin
        prod_xy <= xy_full;
      end
      ecgim_pkg::CFG_CMUL2: begin
        cnt        <= cnt_full[ecgim_pkg::CNT_W-1:0];
        dxdy[cidx] <= prod_xy;
      end
      ecgim_pkg::CFG_CACC: begin
        end_acc        <= acc_next;
        set_ends[cidx] <= acc_next[ecgim_pkg::ID_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    tables.busy     = (state != ecgim_pkg::CFG_IDLE);
    tables.reso     = rc;
    tables.dim_x    = dim_x;
    tables.dim_y    = dim_y;
    tables.dxdy     = dxdy;
    tables.set_ends = set_ends;
    tables.area     = area;
    tables.vol      = vol;
  end

endmodule

`default_nettype wire

### rtl/core/ecgim_front.sv
// Front end: accepts requests, range-checks and classifies them, picks the
// dividend and divisors, and queues the result. Depends on ecgim_pkg, ecgim_in_if.
`default_nettype none

module ecgim_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  ecgim_pkg::tables_t      tables,
  ecgim_in_if.sink                in_ch,
  input  wire logic               pop,
  output ecgim_pkg::q_entry_t     head,
  output logic                    head_valid
);

  localparam int Q_DEPTH = 2;
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int PTR_W   = $clog2(Q_DEPTH);

  ecgim_pkg::q_entry_t mem [Q_DEPTH];
  ecgim_pkg::q_entry_t entry;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic push;

  logic [ecgim_pkg::RESO_W-1:0]  v0, v1;
  logic                          found;
  logic [ecgim_pkg::COLOR_W-1:0] c;
  logic [ecgim_pkg::ID_W-1:0]    base;

  always_comb begin
    v0 = tables.reso[0] + ecgim_pkg::RESO_W'(in_ch.period_dof);
    v1 = tables.reso[1] + ecgim_pkg::RESO_W'(in_ch.period_dof);
    found = 1'b0;
    c     = '0;
    for (int i = ecgim_pkg::NUM_COLORS - 1; i >= 0; i--) begin
      if (in_ch.index_in < tables.set_ends[i]) begin
        found = 1'b1;
        c     = ecgim_pkg::COLOR_W'(i);
      end
    end
    base = (c == '0) ? '0 : tables.set_ends[c - ecgim_pkg::COLOR_W'(1)];

    entry.op    = in_ch.operation;
    entry.per   = in_ch.period_dof;
    entry.bad   = 1'b1;
    entry.color = '0;
    entry.num   = in_ch.index_in;
    entry.d1    = ecgim_pkg::RESO_W'(1);
    entry.d2    = ecgim_pkg::RESO_W'(1);
    case (in_ch.operation)
      ecgim_pkg::OP_LEX2COL: begin
        entry.bad = (in_ch.index_in >= tables.vol[in_ch.period_dof]);
        entry.d1  = v0;
        entry.d2  = v1;
      end
      ecgim_pkg::OP_COL2POS, ecgim_pkg::OP_COL2LEX: begin
        entry.bad   = !found;
        entry.color = c;
        entry.num   = in_ch.index_in - base;
        entry.d1    = ecgim_pkg::RESO_W'(tables.dim_x[c[0]]);
        entry.d2    = ecgim_pkg::RESO_W'(tables.dim_y[c[1]]);
      end
      default: ;
    endcase
  end

  assign in_ch.ready = !tables.busy && (count != CNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = mem[rd_ptr];
  assign head_valid  = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/ecgim_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a payload
// that travels alongside. No dependencies.
`default_nettype none

module ecgim_div_pipe #(
  parameter int DW = 31,
  parameter int VW = 11,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_num,
  input  wire logic [VW-1:0] in_den,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output logic [DW-1:0]      out_quo,
  output logic [VW-1:0]      out_rem,
  output logic [PW-1:0]      out_pay
);

  logic          v_s [DW+1];
  logic [DW-1:0] n_s [DW+1];
  logic [VW-1:0] r_s [DW+1];
  logic [VW-1:0] d_s [DW+1];
  logic [PW-1:0] p_s [DW+1];

  assign v_s[0] = in_valid;
  assign n_s[0] = in_num;
  assign r_s[0] = '0;
  assign d_s[0] = in_den;
  assign p_s[0] = in_pay;

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        take;

    assign trial = {r_s[i], n_s[i][DW-1]};
    assign diff  = trial - {1'b0, d_s[i]};
    assign take  = (trial >= {1'b0, d_s[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i+1] <= take ? diff[VW-1:0] : trial[VW-1:0];
        n_s[i+1] <= {n_s[i][DW-2:0], take};
        d_s[i+1] <= d_s[i];
        p_s[i+1] <= p_s[i];
      end
    end
  end

  assign out_valid = v_s[DW];
  assign out_quo   = n_s[DW];
  assign out_rem   = r_s[DW];
  assign out_pay   = p_s[DW];

endmodule

`default_nettype wire

### rtl/core/ecgim_back.sv
// Back end: two chained divider pipes split an id into axis coordinates,
// modulo pipes wrap positions, then multiply, sum and register the result.
// Depends on ecgim_pkg, ecgim_div_pipe, ecgim_out_if.
`default_nettype none

module ecgim_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  ecgim_pkg::tables_t      tables,
  input  ecgim_pkg::q_entry_t     head,
  input  wire logic               head_valid,
  output logic                    pop,
  ecgim_out_if.source             out_ch
);

  localparam int D1_PW  = $bits(ecgim_pkg::div1_pay_t);
  localparam int D2_PW  = $bits(ecgim_pkg::div2_pay_t);
  localparam int PST_W  = $bits(ecgim_pkg::post_t);
  localparam int LANE_W = PST_W / 3;
  localparam int LANE_Z = PST_W - 2 * LANE_W;

  logic en;
  logic out_valid;

  ecgim_pkg::div1_pay_t d1_in, d1_out;
  logic                          d1_valid;
  logic [ecgim_pkg::ID_W-1:0]    q1;
  logic [ecgim_pkg::RESO_W-1:0]  rem1;
  logic [D1_PW-1:0]              d1_pay_out;

  ecgim_pkg::div2_pay_t d2_in, d2_out;
  logic                          d2_valid;
  logic [ecgim_pkg::ID_W-1:0]    q2;
  logic [ecgim_pkg::RESO_W-1:0]  rem2;
  logic [D2_PW-1:0]              d2_pay_out;

  ecgim_pkg::post_t post_next, post;
  logic             post_v;
  logic [PST_W-1:0] post_vec, mod_vec;
  logic [2:0][ecgim_pkg::POS_W-1:0]  xk;
  logic [2:0][ecgim_pkg::RESO_W-1:0] wk;
  logic [2:0]                        mv;

  ecgim_pkg::post_t mp;
  ecgim_pkg::mul_t  mul_next, mul;
  logic             mul_v;

  logic [2:0][ecgim_pkg::RESO_W-1:0] g;
  logic [ecgim_pkg::COLOR_W-1:0]     col;
  logic [ecgim_pkg::RESO_W:0]        pinc;
  logic [ecgim_pkg::RESO_W-1:0]      ma1, mb1, ma2;
  logic [ecgim_pkg::AREA_W-1:0]      mb2;
  logic [ecgim_pkg::RESO_W-1:0]      v0;
  logic [ecgim_pkg::ID_W+1:0]        sum;

  logic [ecgim_pkg::ID_W-1:0]           index_out;
  logic signed [ecgim_pkg::POS_W-1:0]   pos_x, pos_y, pos_z;
  logic [ecgim_pkg::COLOR_W-1:0]        color;
  logic                                 bad_index;

  assign en  = !out_valid || out_ch.ready;
  assign pop = en && head_valid;

  always_comb begin
    d1_in.op    = head.op;
    d1_in.per   = head.per;
    d1_in.bad   = head.bad;
    d1_in.color = head.color;
    d1_in.d2    = head.d2;
  end

  ecgim_div_pipe #(.DW(ecgim_pkg::ID_W), .VW(ecgim_pkg::RESO_W), .PW(D1_PW)) u_div1 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(head_valid), .in_num(head.num), .in_den(head.d1), .in_pay(d1_in),
    .out_valid(d1_valid), .out_quo(q1), .out_rem(rem1), .out_pay(d1_pay_out)
  );

  always_comb begin
    d1_out      = ecgim_pkg::div1_pay_t'(d1_pay_out);
    d2_in.op    = d1_out.op;
    d2_in.per   = d1_out.per;
    d2_in.bad   = d1_out.bad;
    d2_in.color = d1_out.color;
    d2_in.r0    = rem1;
  end

  ecgim_div_pipe #(.DW(ecgim_pkg::ID_W), .VW(ecgim_pkg::RESO_W), .PW(D2_PW)) u_div2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid), .in_num(q1), .in_den(d1_out.d2), .in_pay(d2_in),
    .out_valid(d2_valid), .out_quo(q2), .out_rem(rem2), .out_pay(d2_pay_out)
  );

  always_comb begin
    d2_out = ecgim_pkg::div2_pay_t'(d2_pay_out);
    g[0]   = d2_out.r0;
    g[1]   = rem2;
    g[2]   = q2[ecgim_pkg::RESO_W-1:0];
    if (d2_out.op == ecgim_pkg::OP_LEX2COL) begin
      col = {~g[2][0], ~g[1][0], ~g[0][0]};
    end else begin
      col = d2_out.color;
    end
    post_next.op    = d2_out.op;
    post_next.per   = d2_out.per;
    post_next.bad   = d2_out.bad;
    post_next.color = col;
    for (int k = 0; k < 3; k++) begin
      pinc              = {1'b0, g[k]} + (ecgim_pkg::RESO_W+1)'(1);
      post_next.ph[k]   = pinc[ecgim_pkg::RESO_W:1];
      post_next.pos[k]  = {g[k], d2_out.color[k]} - ecgim_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      post_v <= 1'b0;
    end else if (en) begin
      post_v <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      post <= post_next;
    end
  end

  always_comb begin
    post_vec = post;
    for (int k = 0; k < 3; k++) begin
      xk[k] = post.pos[k] + ecgim_pkg::POS_W'(tables.reso[k]);
    end
  end

  ecgim_div_pipe #(.DW(ecgim_pkg::POS_W), .VW(ecgim_pkg::RESO_W), .PW(LANE_W)) u_mod_x (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(post_v), .in_num(xk[0]), .in_den(tables.reso[0]),
    .in_pay(post_vec[LANE_W-1:0]),
    .out_valid(mv[0]), .out_quo(), .out_rem(wk[0]),
    .out_pay(mod_vec[LANE_W-1:0])
  );

  ecgim_div_pipe #(.DW(ecgim_pkg::POS_W), .VW(ecgim_pkg::RESO_W), .PW(LANE_W)) u_mod_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(post_v), .in_num(xk[1]), .in_den(tables.reso[1]),
    .in_pay(post_vec[2*LANE_W-1:LANE_W]),
    .out_valid(mv[1]), .out_quo(), .out_rem(wk[1]),
    .out_pay(mod_vec[2*LANE_W-1:LANE_W])
  );

  ecgim_div_pipe #(.DW(ecgim_pkg::POS_W), .VW(ecgim_pkg::RESO_W), .PW(LANE_Z)) u_mod_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(post_v), .in_num(xk[2]), .in_den(tables.reso[2]),
    .in_pay(post_vec[PST_W-1:2*LANE_W]),
    .out_valid(mv[2]), .out_quo(), .out_rem(wk[2]),
    .out_pay(mod_vec[PST_W-1:2*LANE_W])
  );

  always_comb begin
    mp = ecgim_pkg::post_t'(mod_vec);
    v0 = tables.reso[0] + ecgim_pkg::RESO_W'(mp.per);
    mul_next.op    = mp.op;
    mul_next.bad   = mp.bad;
    mul_next.color = mp.color;
    mul_next.pos   = mp.pos;
    if (mp.op == ecgim_pkg::OP_LEX2COL) begin
      mul_next.a0   = mp.ph[0];
      ma1           = mp.ph[1];
      mb1           = ecgim_pkg::RESO_W'(tables.dim_x[mp.color[0]]);
      ma2           = mp.ph[2];
      mb2           = ecgim_pkg::AREA_W'(tables.dxdy[mp.color]);
      mul_next.base = (mp.color == '0) ? '0 :
                      tables.set_ends[mp.color - ecgim_pkg::COLOR_W'(1)];
    end else begin
      mul_next.a0   = wk[0];
      ma1           = wk[1];
      mb1           = v0;
      ma2           = wk[2];
      mb2           = tables.area[mp.per];
      mul_next.base = '0;
    end
    mul_next.m1 = ma1 * mb1;
    mul_next.m2 = ma2 * mb2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else if (en) begin
      mul_v <= mv[0] && mv[1] && mv[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul <= mul_next;
    end
  end

  assign sum = (ecgim_pkg::ID_W+2)'(mul.a0) + (ecgim_pkg::ID_W+2)'(mul.m1) +
               (ecgim_pkg::ID_W+2)'(mul.m2) + (ecgim_pkg::ID_W+2)'(mul.base);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mul_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index_out <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= '0;
      color     <= '0;
      bad_index <= 1'b1;
      if (!mul.bad) begin
        case (mul.op)
          ecgim_pkg::OP_LEX2COL, ecgim_pkg::OP_COL2LEX: begin
            index_out <= sum[ecgim_pkg::ID_W-1:0];
            color     <= mul.color;
            bad_index <= 1'b0;
          end
          ecgim_pkg::OP_COL2POS: begin
            pos_x     <= mul.pos[0];
            pos_y     <= mul.pos[1];
            pos_z     <= mul.pos[2];
            color     <= mul.color;
            bad_index <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.index_out = index_out;
  assign out_ch.pos_x     = pos_x;
  assign out_ch.pos_y     = pos_y;
  assign out_ch.pos_z     = pos_z;
  assign out_ch.color     = color;
  assign out_ch.bad_index = bad_index;

endmodule

`default_nettype wire

### rtl/core/eight_color_grid_index_mapper.sv
// Top level of the eight-color grid index mapper: register port, front end
// with queue, and divider back end. Depends on ecgim_pkg, the channel
// interfaces, ecgim_cfg, ecgim_front, ecgim_back.
//
//   channel   direction  handshake              payload
//   in_ch     in         valid/ready            operation, index_in, period_dof
//   out_ch    out        valid/ready            index_out, pos_x/y/z, color, bad_index
//   apb       in         psel/penable/pready    paddr, pwdata, prdata (reso_x/y/z)
//
// One item per cycle sustained while out_ch takes results and the table sequencer
// is idle; the back end holds two 31-stage divider pipes and three 12-stage modulo pipes.
// After reset and after each write to a resolution register the table sequencer
// runs, and in_ch.ready is low until it is done.
// A stall on out_ch freezes the back end; the two-entry queue keeps the
// front end accepting until it fills.
`default_nettype none

module eight_color_grid_index_mapper (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ecgim_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [ecgim_pkg::PDATA_W-1:0]   pwdata,
  output logic      [ecgim_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready,
  ecgim_in_if.sink                             in_ch,
  ecgim_out_if.source                          out_ch
);

  ecgim_pkg::tables_t  tables;
  ecgim_pkg::q_entry_t head;
  logic                head_valid;
  logic                pop;

  ecgim_cfg u_cfg (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .tables(tables)
  );

  ecgim_front u_front (
    .clk(clk), .rst(rst), .tables(tables), .in_ch(in_ch),
    .pop(pop), .head(head), .head_valid(head_valid)
  );

  ecgim_back u_back (
    .clk(clk), .rst(rst), .tables(tables), .head(head),
    .head_valid(head_valid), .pop(pop), .out_ch(out_ch)
  );

endmodule

`default_nettype wire
